// File: src/lsp_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package lsp_pkg;

	localparam int MAX_NODES = 16;
	localparam int NODE_W    = 4;
	localparam int NCNT_W    = 5;
	localparam int COST_BITS = 16;
	localparam int PATH_W    = 20;
	localparam int HOP_W     = 5;
	localparam int LINK_W    = 2 * NODE_W + COST_BITS;

	localparam logic [PATH_W-1:0] PATH_MAX         = '1;
	localparam logic [HOP_W-1:0]  NO_HOP           = HOP_W'(MAX_NODES);
	localparam logic [NCNT_W-1:0] NODE_COUNT_RESET = NCNT_W'(MAX_NODES);

	localparam logic [1:0] CMD_CLEAR = 2'd0;
	localparam logic [1:0] CMD_ADD   = 2'd1;
	localparam logic [1:0] CMD_RUN   = 2'd2;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_INIT,
		ST_SCAN,
		ST_PICK,
		ST_RL_RD,
		ST_RL_CHK,
		ST_RL_UPD,
		ST_EM_RD,
		ST_EM_WR
	} state_t;

endpackage

`default_nettype wire

// File: src/lsp_if.sv
`timescale 1ns / 1ps
`default_nettype none

interface lsp_req_if;
	logic                        valid;
	logic                        ready;
	logic [1:0]                  command;
	logic [lsp_pkg::NODE_W-1:0]  from_node;
	logic [lsp_pkg::NODE_W-1:0]  to_node;
	logic [lsp_pkg::COST_BITS-1:0] link_cost;
	logic [lsp_pkg::NODE_W-1:0]  source_node;

	modport source(output valid, command, from_node, to_node, link_cost, source_node,
		input ready);
	modport sink(input valid, command, from_node, to_node, link_cost, source_node,
		output ready);
endinterface

interface lsp_rsp_if;
	logic                         valid;
	logic                         ready;
	logic [lsp_pkg::NODE_W-1:0]   node_index;
	logic [lsp_pkg::PATH_W-1:0]   path_cost;
	logic [lsp_pkg::HOP_W-1:0]    previous_node;
	logic                         reachable;
	logic                         link_overflow;
	logic                         last;

	modport source(output valid, node_index, path_cost, previous_node, reachable,
		link_overflow, last, input ready);
	modport sink(input valid, node_index, path_cost, previous_node, reachable,
		link_overflow, last, output ready);
endinterface

interface lsp_cfg_if;
	logic                        valid;
	logic                        ready;
	logic [lsp_pkg::NCNT_W-1:0]  data;

	modport source(output valid, data, input ready);
	modport sink(input valid, data, output ready);
endinterface

`default_nettype wire

// File: src/link_state_shortest_path.sv
// Clear and add commands are handled in idle, where the block stays ready for the next command.
// A run reads costs through one cost RAM read port, shared by the scan, the relaxation and
// the output of results, and reads each stored link from the link RAM once per round. Each
// result is read in ST_EM_RD and loaded in ST_EM_WR, which waits while the output is held.
// Reset (arst_n low) empties the link store, clears overflow and sets node_count to 16;
// link and cost RAM contents are undefined until written, with no clearing pass.
`timescale 1ns / 1ps
`default_nettype none

module link_state_shortest_path #(
	parameter int MAX_LINKS = 64
) (
	input  logic       clk,
	input  logic       arst_n,
	lsp_cfg_if.sink    cfg,
	lsp_req_if.sink    req,
	lsp_rsp_if.source  rsp
);

	localparam int LINK_AW = (MAX_LINKS > 1) ? $clog2(MAX_LINKS) : 1;
	localparam int LINK_CW = $clog2(MAX_LINKS + 1);
	localparam int NW      = lsp_pkg::NODE_W;
	localparam int CW      = lsp_pkg::NCNT_W;
	localparam int PW      = lsp_pkg::PATH_W;
	localparam int HW      = lsp_pkg::HOP_W;
	localparam int NN      = lsp_pkg::MAX_NODES;
	localparam int LINK_W_T = lsp_pkg::LINK_W;

	lsp_pkg::state_t state_q, state_d;

	logic [CW-1:0]       node_count_q;
	logic [LINK_CW-1:0]  link_cnt_q;
	logic                ovf_q;
	logic [NW-1:0]       src_q;
	logic [CW-1:0]       scan_q;
	logic                have_pick_q;
	logic [NW-1:0]       pick_q;
	logic [PW-1:0]       pick_cost_q;
	logic [LINK_CW-1:0]  lk_q;
	logic [NW-1:0]       to_q;
	logic [PW-1:0]       sum_q;
	logic [NW-1:0]       e_q;
	logic [NN-1:0]       known_q;
	logic [NN-1:0]       done_q;
	logic [HW-1:0]       hop_q [NN];

	logic                out_valid_q;
	logic [NW-1:0]       out_node_q;
	logic [PW-1:0]       out_cost_q;
	logic [HW-1:0]       out_prev_q;
	logic                out_reach_q;
	logic                out_ovf_q;
	logic                out_last_q;

	logic [CW-1:0]       n_eff;
	logic                src_ok;
	logic [NW-1:0]       eval_idx;
	logic                eval_take;
	logic [LINK_W_T-1:0] link_rd;
	logic [NW-1:0]       lnk_from;
	logic [NW-1:0]       lnk_to;
	logic [lsp_pkg::COST_BITS-1:0] lnk_w;
	logic                lnk_cand;
	logic [PW:0]         sum_full;
	logic [PW-1:0]       sum_sat;
	logic                upd_take;
	logic                out_free;
	logic                emit_last;
	logic                links_done;

	// RAM control
	logic                cost_we;
	logic [NW-1:0]       cost_waddr;
	logic [PW-1:0]       cost_wdata;
	logic [NW-1:0]       cost_raddr;
	logic [PW-1:0]       cost_rd;
	logic                link_we;
	logic [LINK_AW-1:0]  link_raddr;
	logic                req_ready;

	lsp_ram #(
		.WIDTH(LINK_W_T),
		.DEPTH(MAX_LINKS)
	) u_link_ram (
		.clk   (clk),
		.we    (link_we),
		.waddr (link_cnt_q[LINK_AW-1:0]),
		.wdata ({req.from_node, req.to_node, req.link_cost}),
		.raddr (link_raddr),
		.rdata (link_rd)
	);

	lsp_ram #(
		.WIDTH(PW),
		.DEPTH(NN)
	) u_cost_ram (
		.clk   (clk),
		.we    (cost_we),
		.waddr (cost_waddr),
		.wdata (cost_wdata),
		.raddr (cost_raddr),
		.rdata (cost_rd)
	);

	// saturate the router count into 1 .. MAX_NODES
	always_comb begin
		if (node_count_q == '0) begin
			n_eff = CW'(1);
		end else if (node_count_q > CW'(NN)) begin
			n_eff = CW'(NN);
		end else begin
			n_eff = node_count_q;
		end
	end

	assign src_ok     = {1'b0, src_q} < n_eff;
	assign eval_idx   = NW'(scan_q - CW'(1));
	assign eval_take  = (scan_q != '0) && !done_q[eval_idx] && known_q[eval_idx] &&
		(!have_pick_q || (cost_rd < pick_cost_q));
	assign lnk_from   = link_rd[LINK_W_T-1 -: NW];
	assign lnk_to     = link_rd[LINK_W_T-NW-1 -: NW];
	assign lnk_w      = link_rd[lsp_pkg::COST_BITS-1:0];
	assign lnk_cand   = (lnk_from == pick_q) && ({1'b0, lnk_to} < n_eff) && !done_q[lnk_to];
	assign sum_full   = {1'b0, pick_cost_q} + (PW + 1)'(lnk_w);
	assign sum_sat    = sum_full[PW] ? lsp_pkg::PATH_MAX : sum_full[PW-1:0];
	assign upd_take   = !known_q[to_q] || (sum_q < cost_rd);
	assign out_free   = !out_valid_q || rsp.ready;
	assign emit_last  = (CW'(e_q) + CW'(1)) == n_eff;
	assign links_done = lk_q == link_cnt_q;

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			lsp_pkg::ST_IDLE: begin
				if (req.valid && req.command == lsp_pkg::CMD_RUN) begin
					state_d = lsp_pkg::ST_INIT;
				end
			end
			lsp_pkg::ST_INIT: state_d = lsp_pkg::ST_SCAN;
			lsp_pkg::ST_SCAN: begin
				if (scan_q == n_eff) begin
					state_d = lsp_pkg::ST_PICK;
				end
			end
			lsp_pkg::ST_PICK: begin
				state_d = have_pick_q ? lsp_pkg::ST_RL_RD : lsp_pkg::ST_EM_RD;
			end
			lsp_pkg::ST_RL_RD: begin
				state_d = links_done ? lsp_pkg::ST_SCAN : lsp_pkg::ST_RL_CHK;
			end
			lsp_pkg::ST_RL_CHK: begin
				state_d = lnk_cand ? lsp_pkg::ST_RL_UPD : lsp_pkg::ST_RL_RD;
			end
			lsp_pkg::ST_RL_UPD: state_d = lsp_pkg::ST_RL_RD;
			lsp_pkg::ST_EM_RD:  state_d = lsp_pkg::ST_EM_WR;
			lsp_pkg::ST_EM_WR: begin
				if (out_free) begin
					state_d = emit_last ? lsp_pkg::ST_IDLE : lsp_pkg::ST_EM_RD;
				end
			end
			default: state_d = lsp_pkg::ST_IDLE;
		endcase
	end

	// datapath control
	always_comb begin
		req_ready  = 1'b0;
		link_we    = 1'b0;
		link_raddr = lk_q[LINK_AW-1:0];
		cost_we    = 1'b0;
		cost_waddr = to_q;
		cost_wdata = sum_q;
		cost_raddr = scan_q[NW-1:0];
		case (state_q)
			lsp_pkg::ST_IDLE: begin
				req_ready = 1'b1;
				link_we   = req.valid && (req.command == lsp_pkg::CMD_ADD) &&
					(link_cnt_q != LINK_CW'(MAX_LINKS));
			end
			lsp_pkg::ST_INIT: begin
				cost_we    = src_ok;
				cost_waddr = src_q;
				cost_wdata = '0;
			end
			lsp_pkg::ST_RL_CHK: cost_raddr = lnk_to;
			lsp_pkg::ST_RL_UPD: cost_we = upd_take;
			lsp_pkg::ST_EM_RD:  cost_raddr = e_q;
			lsp_pkg::ST_EM_WR:  cost_raddr = e_q;
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= lsp_pkg::ST_IDLE;
			node_count_q <= lsp_pkg::NODE_COUNT_RESET;
			link_cnt_q   <= '0;
			ovf_q        <= 1'b0;
			src_q        <= '0;
			scan_q       <= '0;
			have_pick_q  <= 1'b0;
			pick_q       <= '0;
			pick_cost_q  <= '0;
			lk_q         <= '0;
			to_q         <= '0;
			sum_q        <= '0;
			e_q          <= '0;
			known_q      <= '0;
			done_q       <= '0;
			out_valid_q  <= 1'b0;
			out_node_q   <= '0;
			out_cost_q   <= '0;
			out_prev_q   <= lsp_pkg::NO_HOP;
			out_reach_q  <= 1'b0;
			out_ovf_q    <= 1'b0;
			out_last_q   <= 1'b0;
			for (int i = 0; i < NN; i++) begin
				hop_q[i] <= lsp_pkg::NO_HOP;
			end
		end else begin
			state_q <= state_d;
			if (cfg.valid) begin
				node_count_q <= cfg.data;
			end
			// drop the result once taken, unless a new one loads this cycle
			if (out_valid_q && rsp.ready && state_q != lsp_pkg::ST_EM_WR) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				lsp_pkg::ST_IDLE: begin
					if (req.valid) begin
						case (req.command)
							lsp_pkg::CMD_CLEAR: begin
								link_cnt_q <= '0;
								ovf_q      <= 1'b0;
							end
							lsp_pkg::CMD_ADD: begin
								if (link_cnt_q != LINK_CW'(MAX_LINKS)) begin
									link_cnt_q <= link_cnt_q + LINK_CW'(1);
								end else begin
									ovf_q <= 1'b1;
								end
							end
							lsp_pkg::CMD_RUN: src_q <= req.source_node;
							default: begin
							end
						endcase
					end
				end
				lsp_pkg::ST_INIT: begin
					done_q      <= '0;
					known_q     <= src_ok ? (NN'(1) << src_q) : '0;
					for (int i = 0; i < NN; i++) begin
						hop_q[i] <= lsp_pkg::NO_HOP;
					end
					scan_q      <= '0;
					have_pick_q <= 1'b0;
				end
				lsp_pkg::ST_SCAN: begin
					// evaluate the entry read last cycle while the next read goes out
					if (eval_take) begin
						have_pick_q <= 1'b1;
						pick_q      <= eval_idx;
						pick_cost_q <= cost_rd;
					end
					if (scan_q != n_eff) begin
						scan_q <= scan_q + CW'(1);
					end
				end
				lsp_pkg::ST_PICK: begin
					if (have_pick_q) begin
						done_q[pick_q] <= 1'b1;
					end
					lk_q <= '0;
					e_q  <= '0;
				end
				lsp_pkg::ST_RL_RD: begin
					if (links_done) begin
						scan_q      <= '0;
						have_pick_q <= 1'b0;
					end else begin
						lk_q <= lk_q + LINK_CW'(1);
					end
				end
				lsp_pkg::ST_RL_CHK: begin
					to_q  <= lnk_to;
					sum_q <= sum_sat;
				end
				lsp_pkg::ST_RL_UPD: begin
					if (upd_take) begin
						known_q[to_q] <= 1'b1;
						hop_q[to_q]   <= HW'(pick_q);
					end
				end
				lsp_pkg::ST_EM_WR: begin
					if (out_free) begin
						out_valid_q <= 1'b1;
						out_node_q  <= e_q;
						out_cost_q  <= known_q[e_q] ? cost_rd : '0;
						out_prev_q  <= known_q[e_q] ? hop_q[e_q] : lsp_pkg::NO_HOP;
						out_reach_q <= known_q[e_q];
						out_ovf_q   <= ovf_q;
						out_last_q  <= emit_last;
						e_q         <= e_q + NW'(1);
					end
				end
				default: begin
				end
			endcase
		end
	end

	assign cfg.ready         = 1'b1;
	assign req.ready         = req_ready;
	assign rsp.valid         = out_valid_q;
	assign rsp.node_index    = out_node_q;
	assign rsp.path_cost     = out_cost_q;
	assign rsp.previous_node = out_prev_q;
	assign rsp.reachable     = out_reach_q;
	assign rsp.link_overflow = out_ovf_q;
	assign rsp.last          = out_last_q;

endmodule

`default_nettype wire

// File: src/lsp_ram.sv
`timescale 1ns / 1ps
`default_nettype none

module lsp_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                                    clk,
	input  logic                                    we,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                        wdata,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                        rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata_q <= mem_q[raddr];
	end

	assign rdata = rdata_q;

endmodule

`default_nettype wire
